// File: rtl/acfb_pkg.sv
// ----------------------------------------------------------------------------
// acfb_pkg
// Shared types and constants for the ARGB crossfade blend pipeline.
// ----------------------------------------------------------------------------
package acfb_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = 8;
    localparam int NUM_W    = 2 * CH_W;
    localparam int PIX_W    = CHANNELS * CH_W;
    localparam int STEP_W   = 8;
    localparam int QBITS    = CH_W;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = PIX_W;

    localparam int PADDR_W = 3;

    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 8'd30;

    typedef enum logic [0:0] {
        REG_STEP_COUNT = 1'b0
    } acfb_reg_t;

    typedef struct packed {
        logic [CHANNELS-1:0][NUM_W-1:0] rem;
        logic [CHANNELS-1:0][CH_W-1:0]  quot;
        logic [STEP_W-1:0]              divisor;
    } acfb_word_t;

endpackage

// File: rtl/argb_crossfade_blend.sv
// ----------------------------------------------------------------------------
// argb_crossfade_blend
// Linear crossfade of two ARGB8888 pixels by a clamped transition step.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock and returns one blended pixel per clock
// while the output is not stalled: a front register forms the weighted
// channel sums, then a row of eight division cells, each resolving one
// quotient bit for all four channels, divides by the step count. Each
// stage holds its word until the next stage takes it, so empty stages
// keep filling while a finished pixel waits at the output.
// ----------------------------------------------------------------------------
module argb_crossfade_blend (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // source_pixel[31:0], end_pixel[63:32], step[71:64]
    input  logic [acfb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // blended_pixel[31:0]
    output logic [acfb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acfb_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int NCELLS = acfb_pkg::QBITS;

    logic [acfb_pkg::STEP_W-1:0] step_count_reg;
    logic [acfb_pkg::STEP_W-1:0] step_count_next;
    logic                        reg_write;
    acfb_pkg::acfb_reg_t         reg_sel;

    acfb_pkg::acfb_word_t        stage_word  [NCELLS+1];
    logic [NCELLS:0]             stage_valid;
    logic [NCELLS:0]             stage_ready;

    assign pready    = 1'b1;
    assign reg_sel   = acfb_pkg::acfb_reg_t'(paddr[2]);
    assign reg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        step_count_next = step_count_reg;
        prdata          = '0;
        unique case (reg_sel)
            acfb_pkg::REG_STEP_COUNT:
            begin
                prdata = {24'd0, step_count_reg};
                if (reg_write)
                begin
                    step_count_next = pwdata[acfb_pkg::STEP_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= acfb_pkg::STEP_COUNT_RESET;
        end
        else
        begin
            step_count_reg <= step_count_next;
        end
    end

    acfb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .source_pixel (s_axis_tdata[31:0]),
        .end_pixel    (s_axis_tdata[63:32]),
        .step         (s_axis_tdata[71:64]),
        .step_count   (step_count_reg),
        .out_valid    (stage_valid[0]),
        .out_ready    (stage_ready[0]),
        .out_word     (stage_word[0])
    );

    for (genvar j = 0; j < NCELLS; j++)
    begin : g_cell
        acfb_div_cell #(
            .SHIFT (NCELLS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[j]),
            .in_ready  (stage_ready[j]),
            .in_word   (stage_word[j]),
            .out_valid (stage_valid[j+1]),
            .out_ready (stage_ready[j+1]),
            .out_word  (stage_word[j+1])
        );
    end

    assign stage_ready[NCELLS] = m_axis_tready;
    assign m_axis_tvalid       = stage_valid[NCELLS];

    always_comb
    begin
        for (int c = 0; c < acfb_pkg::CHANNELS; c++)
        begin
            m_axis_tdata[c*acfb_pkg::CH_W +: acfb_pkg::CH_W] = stage_word[NCELLS].quot[c];
        end
    end

    // assertions

    a_reg_write: assert property (@(posedge clk) disable iff (!rst_n)
        reg_write && (reg_sel == acfb_pkg::REG_STEP_COUNT)
        |=> step_count_reg == $past(pwdata[acfb_pkg::STEP_W-1:0]))
        else $error("step_count write not taken");

    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid[0] |-> s_axis_tready)
        else $error("input stalled with empty front stage");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |-> stage_word[0].divisor != '0)
        else $error("zero divisor entered the division cells");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (stage_word[NCELLS].rem[0] < acfb_pkg::NUM_W'(stage_word[NCELLS].divisor)) &&
            (stage_word[NCELLS].rem[1] < acfb_pkg::NUM_W'(stage_word[NCELLS].divisor)) &&
            (stage_word[NCELLS].rem[2] < acfb_pkg::NUM_W'(stage_word[NCELLS].divisor)) &&
            (stage_word[NCELLS].rem[3] < acfb_pkg::NUM_W'(stage_word[NCELLS].divisor)))
        else $error("division remainder not below divisor");

endmodule

// File: rtl/acfb_front.sv
// ----------------------------------------------------------------------------
// acfb_front
// Clamps the step and forms the weighted channel sums k*target + (n-k)*source.
// ----------------------------------------------------------------------------
module acfb_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [acfb_pkg::PIX_W-1:0]        source_pixel,
    input  logic [acfb_pkg::PIX_W-1:0]        end_pixel,
    input  logic [acfb_pkg::STEP_W-1:0]       step,
    input  logic [acfb_pkg::STEP_W-1:0]       step_count,
    output logic                              out_valid,
    input  logic                              out_ready,
    output acfb_pkg::acfb_word_t              out_word
);

    logic                        valid_reg;
    logic                        valid_next;
    acfb_pkg::acfb_word_t        word_reg;
    acfb_pkg::acfb_word_t        word_next;
    logic [acfb_pkg::STEP_W-1:0] n;
    logic [acfb_pkg::STEP_W-1:0] k;
    logic [acfb_pkg::STEP_W-1:0] w;
    logic                        load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        logic [acfb_pkg::NUM_W-1:0] pa;
        logic [acfb_pkg::NUM_W-1:0] pb;
        n = (step_count == '0) ? acfb_pkg::STEP_W'(1) : step_count;
        k = (step > n) ? n : step;
        w = n - k;
        word_next = '0;
        word_next.divisor = n;
        for (int c = 0; c < acfb_pkg::CHANNELS; c++)
        begin
            pa = acfb_pkg::NUM_W'(w) * acfb_pkg::NUM_W'(source_pixel[c*acfb_pkg::CH_W +:
                 acfb_pkg::CH_W]);
            pb = acfb_pkg::NUM_W'(k) * acfb_pkg::NUM_W'(end_pixel[c*acfb_pkg::CH_W +:
                 acfb_pkg::CH_W]);
            word_next.rem[c] = pa + pb;
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// File: rtl/acfb_div_cell.sv
// ----------------------------------------------------------------------------
// acfb_div_cell
// One restoring-division cell: resolves one quotient bit on all four channels.
// ----------------------------------------------------------------------------
module acfb_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  acfb_pkg::acfb_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output acfb_pkg::acfb_word_t out_word
);

    logic                       valid_reg;
    logic                       valid_next;
    acfb_pkg::acfb_word_t       word_reg;
    acfb_pkg::acfb_word_t       word_next;
    logic [acfb_pkg::NUM_W-1:0] dsh;
    logic                       load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // divisor aligned to this cell's quotient bit
    assign dsh = acfb_pkg::NUM_W'(in_word.divisor) << SHIFT;

    always_comb
    begin
        logic ge;
        word_next = in_word;
        for (int c = 0; c < acfb_pkg::CHANNELS; c++)
        begin
            ge = (in_word.rem[c] >= dsh);
            word_next.rem[c]  = ge ? (in_word.rem[c] - dsh) : in_word.rem[c];
            word_next.quot[c] = {in_word.quot[c][acfb_pkg::CH_W-2:0], ge};
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// File: tb/sv/tb_argb_crossfade_blend.sv
// ----------------------------------------------------------------------------
// tb_argb_crossfade_blend
// Self-checking testbench for the ARGB crossfade blend pipeline.
// ----------------------------------------------------------------------------
// After reset a short table of pixel pairs runs at the default step count,
// with the obvious results typed in. It covers the step-zero, clamped-step
// and equal-pixel cases. Then the step count is moved through a list of
// settings, among them 0, 1, 2 and 255. At each setting random pixel pairs
// run with steps around and past the count. Every pair without a typed
// result is blended by a local model, and each output word is compared in
// order. The sender works in random bursts and the receiver stalls on its
// own changing pattern. A watchdog ends the run if the stream stops moving.
// ----------------------------------------------------------------------------
module tb_argb_crossfade_blend;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 30;
    localparam int PHASE_ITEMS    = 58;
    localparam logic [acfb_pkg::PADDR_W-1:0] ADDR_STEP_COUNT =
        {acfb_pkg::REG_STEP_COUNT, 2'b00};
    localparam logic [acfb_pkg::PADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;

    typedef struct {
        logic [acfb_pkg::PIX_W-1:0]  src;
        logic [acfb_pkg::PIX_W-1:0]  dst;
        logic [acfb_pkg::STEP_W-1:0] step;
        bit                          typed;
        logic [acfb_pkg::PIX_W-1:0]  blended;
    } pixel_row_t;

    typedef struct {
        logic [acfb_pkg::PIX_W-1:0]  src;
        logic [acfb_pkg::PIX_W-1:0]  dst;
        logic [acfb_pkg::STEP_W-1:0] step;
        logic [acfb_pkg::PIX_W-1:0]  blended;
    } blend_exp_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // source_pixel[31:0], end_pixel[63:32], step[71:64]
    logic [acfb_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // blended_pixel[31:0]
    logic [acfb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [acfb_pkg::PADDR_W-1:0]    paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    logic [acfb_pkg::STEP_W-1:0] step_count_q;
    blend_exp_t                  blend_q[$];
    int                          failures;
    int                          mismatches;
    int                          pixels_sent;
    int                          pixels_seen;
    int                          clamped_steps;
    int                          zero_steps;
    int                          settings_run;
    int                          idle_cycles;
    int                          burst_left;

    argb_crossfade_blend dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [acfb_pkg::PIX_W-1:0] blend_pixel(
        input logic [acfb_pkg::PIX_W-1:0]  src,
        input logic [acfb_pkg::PIX_W-1:0]  dst,
        input logic [acfb_pkg::STEP_W-1:0] step,
        input logic [acfb_pkg::STEP_W-1:0] count);
        int unsigned                n;
        int unsigned                k;
        int unsigned                a;
        int unsigned                b;
        logic [acfb_pkg::PIX_W-1:0] r;
        n = (count == '0) ? 32'd1 : 32'(count);
        k = (32'(step) > n) ? n : 32'(step);
        for (int c = 0; c < acfb_pkg::CHANNELS; c++)
        begin
            a = 32'(src[acfb_pkg::CH_W*c +: acfb_pkg::CH_W]);
            b = 32'(dst[acfb_pkg::CH_W*c +: acfb_pkg::CH_W]);
            r[acfb_pkg::CH_W*c +: acfb_pkg::CH_W] = acfb_pkg::CH_W'((k * b + (n - k) * a) / n);
        end
        return r;
    endfunction

    function automatic logic [acfb_pkg::PIX_W-1:0] rand_pixel();
        logic [acfb_pkg::PIX_W-1:0] p;
        for (int c = 0; c < acfb_pkg::CHANNELS; c++)
        begin
            case ($urandom_range(0, 5))
                0:       p[acfb_pkg::CH_W*c +: acfb_pkg::CH_W] = 8'h00;
                1:       p[acfb_pkg::CH_W*c +: acfb_pkg::CH_W] = 8'hff;
                default: p[acfb_pkg::CH_W*c +: acfb_pkg::CH_W] =
                             acfb_pkg::CH_W'($urandom_range(0, 255));
            endcase
        end
        return p;
    endfunction

    function automatic logic [acfb_pkg::STEP_W-1:0] rand_step(
        input logic [acfb_pkg::STEP_W-1:0] count);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return count;
            2:       return (count == 8'hff) ? count
                            : acfb_pkg::STEP_W'($urandom_range(32'(count) + 1, 255));
            3:       return 8'hff;
            4:       return acfb_pkg::STEP_W'($urandom_range(0, 255));
            default: return acfb_pkg::STEP_W'($urandom_range(0, 32'(count)));
        endcase
    endfunction

    task automatic apb_write(input logic [acfb_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == ADDR_STEP_COUNT)
            step_count_q = data[acfb_pkg::STEP_W-1:0];
    endtask

    task automatic apb_check_step_count();
        logic [31:0] rd;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_STEP_COUNT;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (rd[acfb_pkg::STEP_W-1:0] !== step_count_q)
        begin
            failures++;
            mismatches++;
            if (mismatches <= 10)
                $display("step_count readback: expected %0d, got %0d", step_count_q,
                         rd[acfb_pkg::STEP_W-1:0]);
        end
    endtask

    task automatic set_step_count(input logic [acfb_pkg::STEP_W-1:0] count);
        logic [31:0] data;
        data = {$urandom_range(0, 1) ? 24'($urandom) : 24'h0, count};
        apb_write(ADDR_STEP_COUNT, data);
        apb_check_step_count();
        settings_run++;
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = acfb_pkg::IN_DATA_W'({$urandom, $urandom, $urandom});
        end
    endtask

    task automatic drain_blends();
        hold_off(1);
        while (blend_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input pixel_row_t row);
        blend_exp_t e;
        if (burst_left == 0)
        begin
            hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {row.step, row.dst, row.src};
        do @(posedge clk); while (!s_axis_tready);
        e.src     = row.src;
        e.dst     = row.dst;
        e.step    = row.step;
        e.blended = row.typed ? row.blended
                              : blend_pixel(row.src, row.dst, row.step, step_count_q);
        blend_q.push_back(e);
        pixels_sent++;
        if (row.step == 0)
            zero_steps++;
        else if (row.step >= step_count_q)
            clamped_steps++;
    endtask

    // receiver stall pattern, switches between random modes
    int rx_mode;
    int rx_left;
    int rx_stall;
    int rx_tick;
    initial
    begin
        rx_mode  = 0;
        rx_left  = 0;
        rx_stall = 0;
        rx_tick  = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: m_axis_tready = 1'b1;
                1: m_axis_tready = $urandom_range(0, 1);
                2: m_axis_tready = (rx_tick % 4) != 0;
                default:
                begin
                    if (rx_stall > 0)
                    begin
                        m_axis_tready = 1'b0;
                        rx_stall--;
                    end
                    else
                    begin
                        m_axis_tready = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            rx_stall = $urandom_range(1, 15);
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        blend_exp_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            pixels_seen++;
            if (blend_q.size() == 0)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: blended_pixel %08h", m_axis_tdata);
            end
            else
            begin
                e = blend_q.pop_front();
                if (m_axis_tdata[acfb_pkg::PIX_W-1:0] !== e.blended)
                begin
                    failures++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("blend mismatch: src %08h dst %08h step %0d count %0d: ",
                                 e.src, e.dst, e.step, step_count_q,
                                 "expected %08h, got %08h", e.blended, m_axis_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    pixel_row_t directed[] = '{
        '{32'h0000_0000, 32'hffff_ffff, 8'd0,   1'b1, 32'h0000_0000},
        '{32'hffff_ffff, 32'h0000_0000, 8'd0,   1'b1, 32'hffff_ffff},
        '{32'h1234_5678, 32'h9abc_def0, 8'd30,  1'b1, 32'h9abc_def0},
        '{32'ha5a5_a5a5, 32'h5a5a_5a5a, 8'd255, 1'b1, 32'h5a5a_5a5a},
        '{32'h0f0f_0f0f, 32'hf0f0_f0f0, 8'd31,  1'b1, 32'hf0f0_f0f0},
        '{32'h00ff_00ff, 32'hff00_ff00, 8'd128, 1'b1, 32'hff00_ff00},
        '{32'h3c3c_3c3c, 32'h3c3c_3c3c, 8'd17,  1'b1, 32'h3c3c_3c3c},
        '{32'hffff_ffff, 32'hffff_ffff, 8'd29,  1'b1, 32'hffff_ffff},
        '{32'h0000_0000, 32'hffff_ffff, 8'd1,   1'b0, 32'h0},
        '{32'hffff_ffff, 32'h0000_0000, 8'd29,  1'b0, 32'h0},
        '{32'h00ff_00ff, 32'hff00_ff00, 8'd15,  1'b0, 32'h0},
        '{32'h8040_2010, 32'h0102_0408, 8'd7,   1'b0, 32'h0},
        '{32'hfe01_7f80, 32'h01fe_807f, 8'd23,  1'b0, 32'h0}
    };

    logic [acfb_pkg::STEP_W-1:0] count_plan[] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3, 8'd128,
                                                  8'd0, 8'd0, 8'd0, 8'd0, 8'd30};

    initial
    begin
        pixel_row_t  row;
        logic [31:0] junk;
        failures      = 0;
        mismatches    = 0;
        pixels_sent   = 0;
        pixels_seen   = 0;
        clamped_steps = 0;
        zero_steps    = 0;
        settings_run  = 1;
        idle_cycles   = 0;
        burst_left    = 0;
        step_count_q  = acfb_pkg::STEP_COUNT_RESET;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // unmapped register index, the write must not land
        junk = $urandom;
        apb_write(ADDR_UNMAPPED, {junk[31:8], 8'd7});
        apb_check_step_count();

        foreach (directed[i])
            send_pixel(directed[i]);
        drain_blends();

        foreach (count_plan[p])
        begin
            set_step_count((count_plan[p] == 0 && p >= 6)
                           ? acfb_pkg::STEP_W'($urandom_range(4, 254))
                           : count_plan[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                row.src   = rand_pixel();
                row.dst   = rand_pixel();
                row.step  = rand_step(step_count_q);
                row.typed = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    row.dst = row.src;
                send_pixel(row);
                if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0)
                    drain_blends();
            end
            drain_blends();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (blend_q.size() != 0)
        begin
            failures++;
            $display("%0d blended pixels never arrived", blend_q.size());
        end
        $display("covered %0d pixel pairs over %0d step-count settings (0, 1, 2 and 255 included)",
                 pixels_sent, settings_run);
        $display("%0d zero steps, %0d clamped steps, %0d words checked, %0d mismatches",
                 zero_steps, clamped_steps, pixels_seen, mismatches);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/acfb_pkg.sv
rtl/acfb_front.sv
rtl/acfb_div_cell.sv
rtl/argb_crossfade_blend.sv
tb/sv/tb_argb_crossfade_blend.sv
